// ----- src/ll1_pkg.sv -----
// Shared types and constants of the LL(1) predictive parse engine.
package ll1_pkg;

  localparam int unsigned NonTerminals = 16;
  localparam int unsigned Terminals    = 16;
  localparam int unsigned Productions  = 64;
  localparam int unsigned BodyMax      = 8;
  localparam int unsigned StackSize    = 64;

  localparam int unsigned CellW  = 7;
  localparam int unsigned TabAw  = 8;
  localparam int unsigned ProdW  = 6;
  localparam int unsigned PosW   = 3;
  localparam int unsigned SymW   = 5;
  localparam int unsigned LenW   = 4;
  localparam int unsigned SpW    = 7;
  localparam int unsigned StkAw  = 6;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CellW-1:0] CellEmpty = 7'h7F;

  typedef enum logic [1:0] {
    OP_TABLE = 2'd0,
    OP_PROD  = 2'd1,
    OP_START = 2'd2,
    OP_TOKEN = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_LOADED   = 4'd0,
    ST_CONSUMED = 4'd1,
    ST_ACCEPT   = 4'd2,
    ST_MISMATCH = 4'd3,
    ST_LEXICAL  = 4'd4,
    ST_NOENTRY  = 4'd5,
    ST_OVERFLOW = 4'd6,
    ST_LIMIT    = 4'd7,
    ST_IDLE     = 4'd8
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SYM = 3'd0,
    CFG_END_TERM  = 3'd1,
    CFG_NUM_TERM  = 3'd2,
    CFG_EXP_LIMIT = 3'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    tbl_wr;
    logic    prod_wr;
    logic    st0_wr;
    logic    st1_wr;
    logic    stk_rd;
    logic    tbl_rd;
    logic    len_rd;
    logic    exp_setup;
    logic    bsym_rd;
    logic    bsym_wr;
    logic    exp_finish;
    logic    consume;
    logic    stop;
    logic    stat_we;
    status_e stat;
  } cmd_t;

  // Status flags from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic parsing;
    logic sp_bad;
    logic top_is_term;
    logic top_match;
    logic top_is_end;
    logic at_limit;
    logic lexical;
    logic cell_bad;
    logic overflow;
    logic body_empty;
    logic body_last;
  } sts_t;

endpackage

// ----- src/ll1_ctrl.sv -----
// Controller state machine of the LL(1) predictive parse engine.
module ll1_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ll1_pkg::sts_t sts_i,
  output ll1_pkg::cmd_t cmd_o
);
  import ll1_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_EXEC = 11'b000_0000_0010,
    S_ST1  = 11'b000_0000_0100,
    S_TOP  = 11'b000_0000_1000,
    S_DEC  = 11'b000_0001_0000,
    S_CELL = 11'b000_0010_0000,
    S_LEN  = 11'b000_0100_0000,
    S_BRD  = 11'b000_1000_0000,
    S_BWR  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // Sequence one transaction
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.stat = ST_LOADED;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.stat_we = 1'b1;
        state_d = S_DONE;
        case (sts_i.op)
          OP_TABLE: cmd_o.tbl_wr = 1'b1;
          OP_PROD:  cmd_o.prod_wr = 1'b1;
          OP_START: begin
            cmd_o.st0_wr = 1'b1;
            state_d = S_ST1;
          end
          default: begin
            if (!sts_i.parsing) begin
              cmd_o.stat = ST_IDLE;
            end else begin
              cmd_o.stat_we = 1'b0;
              state_d = S_TOP;
            end
          end
        endcase
      end
      S_ST1: begin
        cmd_o.st1_wr = 1'b1;
        state_d = S_DONE;
      end
      S_TOP: begin
        if (sts_i.sp_bad) begin
          cmd_o.stop = 1'b1;
          cmd_o.stat_we = 1'b1;
          cmd_o.stat = ST_MISMATCH;
          state_d = S_DONE;
        end else begin
          cmd_o.stk_rd = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.top_is_term) begin
          cmd_o.stat_we = 1'b1;
          state_d = S_DONE;
          if (!sts_i.top_match) begin
            cmd_o.stop = 1'b1;
            cmd_o.stat = ST_MISMATCH;
          end else if (sts_i.top_is_end) begin
            cmd_o.stop = 1'b1;
            cmd_o.stat = ST_ACCEPT;
          end else begin
            cmd_o.consume = 1'b1;
            cmd_o.stat = ST_CONSUMED;
          end
        end else if (sts_i.at_limit) begin
          cmd_o.stop = 1'b1;
          cmd_o.stat_we = 1'b1;
          cmd_o.stat = ST_LIMIT;
          state_d = S_DONE;
        end else if (sts_i.lexical) begin
          cmd_o.stop = 1'b1;
          cmd_o.stat_we = 1'b1;
          cmd_o.stat = ST_LEXICAL;
          state_d = S_DONE;
        end else begin
          cmd_o.tbl_rd = 1'b1;
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        if (sts_i.cell_bad) begin
          cmd_o.stop = 1'b1;
          cmd_o.stat_we = 1'b1;
          cmd_o.stat = ST_NOENTRY;
          state_d = S_DONE;
        end else begin
          cmd_o.len_rd = 1'b1;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (sts_i.overflow) begin
          cmd_o.stop = 1'b1;
          cmd_o.stat_we = 1'b1;
          cmd_o.stat = ST_OVERFLOW;
          state_d = S_DONE;
        end else begin
          cmd_o.exp_setup = 1'b1;
          state_d = sts_i.body_empty ? S_FIN : S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.bsym_rd = 1'b1;
        state_d = S_BWR;
      end
      S_BWR: begin
        cmd_o.bsym_wr = 1'b1;
        state_d = sts_i.body_last ? S_FIN : S_BRD;
      end
      S_FIN: begin
        cmd_o.exp_finish = 1'b1;
        state_d = S_TOP;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/ll1_dpath.sv -----
// Datapath of the LL(1) predictive parse engine: stores, stack and counters.
module ll1_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ll1_pkg::cmd_t                cmd_i,
  output ll1_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [ll1_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ll1_pkg::CfgDatW-1:0]  cfg_data_i,
  input  logic [1:0]                   operation_i,
  input  logic [3:0]                   nonterminal_i,
  input  logic [3:0]                   terminal_i,
  input  logic signed [6:0]            table_production_i,
  input  logic [5:0]                   production_i,
  input  logic [2:0]                   rhs_position_i,
  input  logic [4:0]                   rhs_symbol_i,
  input  logic [3:0]                   rhs_length_i,
  output logic [3:0]                   status_o,
  output logic [6:0]                   stack_depth_o,
  output logic [7:0]                   expansions_o
);
  import ll1_pkg::*;

  // Configuration registers
  logic [3:0]      start_sym_q, end_term_q;
  logic [4:0]      num_term_q;
  logic [ExpW-1:0] exp_limit_q;

  // Captured transaction fields
  op_e             op_q;
  logic [3:0]      nt_q, tok_q;
  logic [CellW-1:0] tcell_q;
  logic [ProdW-1:0] prod_q;
  logic [PosW-1:0] pos_q;
  logic [SymW-1:0] sym_q;
  logic [LenW-1:0] len_q;

  // Memories
  logic [CellW-1:0] tbl_mem [NonTerminals*Terminals];
  logic             tbl_vld_q [NonTerminals*Terminals];
  logic [SymW-1:0]  bsym_mem [Productions*BodyMax];
  logic [LenW-1:0]  blen_mem [Productions];
  logic [SymW-1:0]  stk_mem [StackSize];

  logic [SymW-1:0]  top_q, bsym_q;
  logic [CellW-1:0] cell_q;
  logic [LenW-1:0]  lenrd_q;

  logic             parsing_q;
  logic [SpW-1:0]   sp_q;
  logic [ExpW-1:0]  exps_q;
  status_e          stat_q;

  logic [ProdW-1:0] entry_q;
  logic [StkAw-1:0] base_q;
  logic [LenW-1:0]  blen_q, idx_q;

  logic [LenW-1:0]  len_sat, len_wsat, rd_pos;
  logic [SpW-1:0]   sp_m1, new_top;
  logic [TabAw-1:0] tbl_wa, tbl_ra;

  assign len_sat  = (lenrd_q > LenW'(BodyMax)) ? LenW'(BodyMax) : lenrd_q;
  assign len_wsat = (len_q > LenW'(BodyMax)) ? LenW'(BodyMax) : len_q;
  assign sp_m1    = sp_q - SpW'(1);
  assign new_top  = sp_m1 + SpW'(len_sat);
  assign rd_pos   = blen_q - LenW'(1) - idx_q;
  assign tbl_wa   = {nt_q, tok_q};
  assign tbl_ra   = {top_q[3:0], tok_q};

  // Status flags for the controller
  always_comb begin
    sts_o.op          = op_q;
    sts_o.parsing     = parsing_q;
    sts_o.sp_bad      = (sp_q == '0) || (sp_q > SpW'(StackSize));
    sts_o.top_is_term = !top_q[4];
    sts_o.top_match   = (top_q == {1'b0, tok_q});
    sts_o.top_is_end  = (top_q == {1'b0, end_term_q});
    sts_o.at_limit    = (exps_q >= exp_limit_q);
    sts_o.lexical     = ({1'b0, tok_q} >= num_term_q);
    sts_o.cell_bad    = cell_q[6];
    sts_o.overflow    = (new_top > SpW'(StackSize));
    sts_o.body_empty  = (len_sat == '0);
    sts_o.body_last   = ((idx_q + LenW'(1)) == blen_q);
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_sym_q <= 4'd0;
      end_term_q  <= 4'd15;
      num_term_q  <= 5'd16;
      exp_limit_q <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_SYM: start_sym_q <= cfg_data_i[3:0];
        CFG_END_TERM:  end_term_q  <= cfg_data_i[3:0];
        CFG_NUM_TERM:  num_term_q  <= cfg_data_i[4:0];
        CFG_EXP_LIMIT: exp_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      nt_q    <= nonterminal_i;
      tok_q   <= terminal_i;
      tcell_q <= table_production_i;
      prod_q  <= production_i;
      pos_q   <= rhs_position_i;
      sym_q   <= rhs_symbol_i;
      len_q   <= rhs_length_i;
    end
  end

  // Track parse table cells that hold a written value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NonTerminals*Terminals; i++) begin
        tbl_vld_q[i] <= 1'b0;
      end
    end else if (cmd_i.tbl_wr) begin
      tbl_vld_q[tbl_wa] <= 1'b1;
    end
  end

  // Parse table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) begin
      tbl_mem[tbl_wa] <= tcell_q;
    end
    if (cmd_i.tbl_rd) begin
      cell_q <= tbl_vld_q[tbl_ra] ? tbl_mem[tbl_ra] : CellEmpty;
    end
  end

  // Production stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_wr) begin
      bsym_mem[{prod_q, pos_q}] <= sym_q;
      blen_mem[prod_q] <= len_wsat;
    end
    if (cmd_i.len_rd) begin
      lenrd_q <= blen_mem[cell_q[5:0]];
    end
    if (cmd_i.bsym_rd) begin
      bsym_q <= bsym_mem[{entry_q, rd_pos[PosW-1:0]}];
    end
  end

  // Symbol stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.st0_wr) begin
      stk_mem[StkAw'(0)] <= {1'b0, end_term_q};
    end else if (cmd_i.st1_wr) begin
      stk_mem[StkAw'(1)] <= {1'b1, start_sym_q};
    end else if (cmd_i.bsym_wr) begin
      stk_mem[base_q + StkAw'(idx_q)] <= bsym_q;
    end
    if (cmd_i.stk_rd) begin
      top_q <= stk_mem[sp_m1[StkAw-1:0]];
    end
  end

  // Hold expansion bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_setup) begin
      entry_q <= cell_q[5:0];
      base_q  <= sp_m1[StkAw-1:0];
      blen_q  <= len_sat;
      idx_q   <= '0;
    end else if (cmd_i.bsym_wr) begin
      idx_q <= idx_q + LenW'(1);
    end
  end

  // Parse control state, stack pointer and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parsing_q <= 1'b0;
      sp_q      <= '0;
      exps_q    <= '0;
      stat_q    <= ST_LOADED;
    end else begin
      if (cmd_i.capture) begin
        exps_q <= '0;
      end
      if (cmd_i.st1_wr) begin
        sp_q      <= SpW'(2);
        parsing_q <= 1'b1;
      end
      if (cmd_i.stop) begin
        parsing_q <= 1'b0;
      end
      if (cmd_i.consume) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.exp_finish) begin
        sp_q   <= SpW'(base_q) + SpW'(blen_q);
        exps_q <= exps_q + ExpW'(1);
      end
      if (cmd_i.stat_we) begin
        stat_q <= cmd_i.stat;
      end
    end
  end

  assign status_o      = stat_q;
  assign stack_depth_o = sp_q;
  assign expansions_o  = exps_q;

endmodule

// ----- src/ll1_predictive_parse_engine.sv -----
// Top level of the LL(1) predictive parse engine.
// A transaction is taken when start is high and busy is low; its single result
// appears on status_o, stack_depth_o and expansions_o for one cycle with done_o,
// and the receiver cannot stall it. A token reads the stack top and, for each
// expansion, the parse table cell and the body length, then moves each body
// symbol with a read and a write: the symbol stack, parse table and body stores
// are single-port memories read with a registered output, and body symbols
// move to the stack one at a time. Configuration writes are always ready; the
// parse table is empty after reset through per-cell valid bits, with no
// clearing pass.
module ll1_predictive_parse_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation_i,
  input  logic [3:0]                  nonterminal_i,
  input  logic [3:0]                  terminal_i,
  input  logic signed [6:0]           table_production_i,
  input  logic [5:0]                  production_i,
  input  logic [2:0]                  rhs_position_i,
  input  logic [4:0]                  rhs_symbol_i,
  input  logic [3:0]                  rhs_length_i,
  output logic                        done_o,
  output logic [3:0]                  status_o,
  output logic [6:0]                  stack_depth_o,
  output logic [7:0]                  expansions_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ll1_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ll1_pkg::CfgDatW-1:0] cfg_data_i
);
  import ll1_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ll1_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ll1_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .nonterminal_i      (nonterminal_i),
    .terminal_i         (terminal_i),
    .table_production_i (table_production_i),
    .production_i       (production_i),
    .rhs_position_i     (rhs_position_i),
    .rhs_symbol_i       (rhs_symbol_i),
    .rhs_length_i       (rhs_length_i),
    .status_o           (status_o),
    .stack_depth_o      (stack_depth_o),
    .expansions_o       (expansions_o)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // The result strobe lasts one cycle and frees the block
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy)) else $error("result strobe not single");

  // The result is shown only while a transaction is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result without transaction");

  // Stack depth never exceeds the stack
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (stack_depth_o <= 7'(StackSize))) else $error("stack depth out of range");
`endif

endmodule

// ----- tb/tb_ll1_predictive_parse_engine.sv -----
// Self-checking testbench for the LL(1) predictive parse engine.
`timescale 1ns / 1ps

module tb_ll1_predictive_parse_engine;
  import ll1_pkg::*;

  typedef struct {
    op_e               op;
    logic [3:0]        nt;
    logic [3:0]        term;
    logic signed [6:0] tprod;
    logic [5:0]        prod;
    logic [2:0]        pos;
    logic [4:0]        sym;
    logic [3:0]        len;
  } item_t;

  typedef struct {
    status_e    st;
    logic [6:0] depth;
    logic [7:0] exps;
  } parse_res_t;

  typedef struct {
    item_t      it;
    bit         typed;
    parse_res_t want;
  } dir_row_t;

  localparam int unsigned WatchLimit = 60000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          operation_q = '0;
  logic [3:0]          nonterminal_q = '0;
  logic [3:0]          terminal_q = '0;
  logic signed [6:0]   table_production_q = '0;
  logic [5:0]          production_q = '0;
  logic [2:0]          rhs_position_q = '0;
  logic [4:0]          rhs_symbol_q = '0;
  logic [3:0]          rhs_length_q = '0;
  logic                done_o;
  logic [3:0]          status_o;
  logic [6:0]          stack_depth_o;
  logic [7:0]          expansions_o;
  logic                cfg_valid_q = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_q = '0;
  logic [CfgDatW-1:0]  cfg_data_q = '0;

  ll1_predictive_parse_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_q),
    .nonterminal_i      (nonterminal_q),
    .terminal_i         (terminal_q),
    .table_production_i (table_production_q),
    .production_i       (production_q),
    .rhs_position_i     (rhs_position_q),
    .rhs_symbol_i       (rhs_symbol_q),
    .rhs_length_i       (rhs_length_q),
    .done_o             (done_o),
    .status_o           (status_o),
    .stack_depth_o      (stack_depth_o),
    .expansions_o       (expansions_o),
    .cfg_valid_i        (cfg_valid_q),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_q),
    .cfg_data_i         (cfg_data_q)
  );

  always #4 clk_i = ~clk_i;

  // Shadow state of the engine
  logic [6:0] shadow_table [NonTerminals*Terminals];
  logic [4:0] shadow_body  [Productions*BodyMax];
  logic [3:0] shadow_len   [Productions];
  logic [4:0] shadow_stack [StackSize];
  int         shadow_sp;
  bit         shadow_parsing;
  logic [3:0] start_sym_r;
  logic [3:0] end_term_r;
  logic [4:0] num_term_r;
  logic [7:0] exp_limit_r;

  parse_res_t pending_q[$];
  int         mismatches;
  int         items_sent;
  int         status_seen [9];
  int         idle_cycles;

  // Run one token against the shadow stack, optionally keeping the outcome
  function automatic parse_res_t run_token(input logic [3:0] tok, input bit commit);
    parse_res_t r;
    logic [4:0] s [StackSize];
    int         p;
    int         e;
    int         ent;
    int         blen;
    int         base;
    logic [4:0] top;
    bit         fin;
    s = shadow_stack;
    p = shadow_sp;
    e = 0;
    fin = 1'b0;
    if (!shadow_parsing) begin
      r = '{ST_IDLE, 7'(shadow_sp), 8'd0};
      return r;
    end
    while (!fin) begin
      fin = 1'b1;
      if (p == 0 || p > StackSize) begin
        r.st = ST_MISMATCH;
      end else begin
        top = s[p-1];
        if (top < 16) begin
          if (top != {1'b0, tok}) r.st = ST_MISMATCH;
          else if (top == {1'b0, end_term_r}) r.st = ST_ACCEPT;
          else begin
            p--;
            r.st = ST_CONSUMED;
          end
        end else if (e >= exp_limit_r) begin
          r.st = ST_LIMIT;
        end else if ({1'b0, tok} >= num_term_r) begin
          r.st = ST_LEXICAL;
        end else begin
          ent = shadow_table[{top[3:0], tok}];
          if (ent[6] || ent >= Productions) begin
            r.st = ST_NOENTRY;
          end else begin
            blen = shadow_len[ent];
            if (blen > BodyMax) blen = BodyMax;
            if (p - 1 + blen > StackSize) begin
              r.st = ST_OVERFLOW;
            end else begin
              base = p - 1;
              for (int i = 0; i < blen; i++) s[base+i] = shadow_body[ent*BodyMax + blen - 1 - i];
              p = base + blen;
              e++;
              fin = 1'b0;
            end
          end
        end
      end
    end
    r.depth = 7'(p);
    r.exps  = 8'(e);
    if (commit) begin
      shadow_stack   = s;
      shadow_sp      = p;
      shadow_parsing = (r.st == ST_CONSUMED);
    end
    return r;
  endfunction

  // Apply an accepted transaction to the shadow state and predict its result
  function automatic parse_res_t apply_item(input item_t it);
    parse_res_t r;
    case (it.op)
      OP_TABLE: shadow_table[{it.nt, it.term}] = it.tprod;
      OP_PROD: begin
        shadow_body[{it.prod, it.pos}] = it.sym;
        shadow_len[it.prod] = (it.len > BodyMax) ? 4'(BodyMax) : it.len;
      end
      OP_START: begin
        shadow_stack[0] = {1'b0, end_term_r};
        shadow_stack[1] = {1'b1, start_sym_r};
        shadow_sp       = 2;
        shadow_parsing  = 1'b1;
      end
      default: return run_token(it.term, 1'b1);
    endcase
    r = '{ST_LOADED, 7'(shadow_sp), 8'd0};
    return r;
  endfunction

  function automatic item_t mk(op_e op, int nt, int term, int tp, int pr, int pos, int sym,
                               int len);
    item_t it;
    it = '{op, 4'(nt), 4'(term), 7'(tp), 6'(pr), 3'(pos), 5'(sym), 4'(len)};
    return it;
  endfunction

  // Random fields, with bodies biased toward short mostly-terminal strings
  function automatic item_t rand_fields(op_e op);
    item_t it;
    int    v;
    v = $urandom_range(64);
    it.op    = op;
    it.nt    = 4'($urandom_range(15));
    it.term  = 4'($urandom_range(15));
    it.tprod = (v < 6) ? -7'sd1 : 7'($urandom_range(63));
    it.prod  = 6'($urandom_range(63));
    it.pos   = 3'($urandom_range(7));
    it.sym   = ($urandom_range(99) < 70) ? 5'($urandom_range(15)) : 5'($urandom_range(31, 16));
    v = $urandom_range(99);
    if (v < 5) it.len = 4'($urandom_range(15, 9));
    else if (v < 15) it.len = 4'($urandom_range(8));
    else it.len = 4'($urandom_range(3));
    return it;
  endfunction

  // Pick a token that lets the parse go on, if one exists
  function automatic logic [3:0] guided_token();
    parse_res_t r;
    int         base;
    base = $urandom_range(15);
    for (int k = 0; k < Terminals; k++) begin
      r = run_token(4'(base + k), 1'b0);
      if (r.st == ST_CONSUMED || r.st == ST_ACCEPT) return 4'(base + k);
    end
    return 4'($urandom_range(15));
  endfunction

  // Drive one transaction, starting at a falling edge; leave at a falling edge
  task automatic send(input item_t it, input bit typed, input parse_res_t want);
    parse_res_t pred;
    start              <= 1'b1;
    operation_q        <= it.op;
    nonterminal_q      <= it.nt;
    terminal_q         <= it.term;
    table_production_q <= it.tprod;
    production_q       <= it.prod;
    rhs_position_q     <= it.pos;
    rhs_symbol_q       <= it.sym;
    rhs_length_q       <= it.len;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pred = apply_item(it);
    pending_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Write all four registers once the engine has drained
  task automatic configure(input int ss, input int et, input int nterm, input int lim);
    int vals [4];
    vals = '{ss, et, nterm, lim};
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_q <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_q <= CfgIdxW'(i);
      cfg_data_q  <= CfgDatW'(vals[i]);
      forever begin
        @(posedge clk_i);
        if (cfg_ready_o) break;
      end
      case (cfg_idx_e'(i))
        CFG_START_SYM: start_sym_r = 4'(vals[i]);
        CFG_END_TERM:  end_term_r  = 4'(vals[i]);
        CFG_NUM_TERM:  num_term_r  = 5'(vals[i]);
        default:       exp_limit_r = 8'(vals[i]);
      endcase
      @(negedge clk_i);
    end
    cfg_valid_q <= 1'b0;
  endtask

  // Check every result against the oldest prediction
  always @(posedge clk_i) begin
    parse_res_t w;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status_o);
      end else begin
        w = pending_q.pop_front();
        if (status_o < 9) status_seen[status_o]++;
        if (status_o != 4'(w.st) || stack_depth_o != w.depth || expansions_o != w.exps) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: status %0d/%0d depth %0d/%0d expansions %0d/%0d",
                     w.st, status_o, w.depth, stack_depth_o, w.exps, expansions_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_q && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    dir_row_t   dir_tab[$];
    item_t      it;
    parse_res_t none;
    int         gaps [6];
    int         r;
    int         len;
    gaps = '{0, 88, 0, 15, 88, 0};
    none = '{ST_LOADED, 7'd0, 8'd0};
    mismatches = 0;
    items_sent = 0;
    idle_cycles = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_table[i]) shadow_table[i] = CellEmpty;
    shadow_sp = 0;
    shadow_parsing = 1'b0;
    start_sym_r = 4'd0;
    end_term_r  = 4'd15;
    num_term_r  = 5'd16;
    exp_limit_r = 8'd64;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows; a token while idle must come before any start
    dir_tab.push_back('{mk(OP_TOKEN, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_IDLE, 7'd0, 8'd0}});

    // Fill every body slot so no parse ever reads an unwritten entry
    for (int p = 0; p < Productions; p++) begin
      len = $urandom_range(99) < 85 ? $urandom_range(3) : $urandom_range(15);
      for (int q = 0; q < BodyMax; q++) begin
        it = rand_fields(OP_PROD);
        it.prod = 6'(p);
        it.pos  = 3'(q);
        it.len  = 4'(len);
        dir_tab.push_back('{it, 0, none});
      end
    end
    repeat (128) dir_tab.push_back('{rand_fields(OP_TABLE), 0, none});

    dir_tab.push_back('{mk(OP_TABLE, 0, 3, 1, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 15, 15, -1, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 1, 0, 3, 1), 1, none});
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 2, 0, 16, 2), 1, none});
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 2, 1, 16, 2), 1, none});
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 3, 0, 16, 1), 1, none});
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 4, 7, 31, 0), 1, none});
    // Long body length saturates
    dir_tab.push_back('{mk(OP_PROD, 0, 0, 0, 63, 7, 31, 15), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 0, 7, 2, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 0, 8, 3, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 0, 9, 4, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 0, 15, 4, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 0, 5, -1, 0, 0, 0, 0), 1, none});
    dir_tab.push_back('{mk(OP_TABLE, 1, 0, 63, 0, 0, 0, 0), 1, none});
    // Empty cell
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 5, 0, 0, 0, 0, 0), 1, '{ST_NOENTRY, 7'd2, 8'd0}});
    // Consume, restart while parsing, then accept through an epsilon body
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 3, 0, 0, 0, 0, 0), 1, '{ST_CONSUMED, 7'd1, 8'd1}});
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 15, 0, 0, 0, 0, 0), 1, '{ST_ACCEPT, 7'd1, 8'd1}});
    // Overflow from a growing recursion
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 7, 0, 0, 0, 0, 0), 1, '{ST_OVERFLOW, 7'd64, 8'd62}});
    // Expansion limit on a unit cycle
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 8, 0, 0, 0, 0, 0), 1, '{ST_LIMIT, 7'd2, 8'd64}});
    // Epsilon then a terminal that does not match
    dir_tab.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_LOADED, 7'd2, 8'd0}});
    dir_tab.push_back('{mk(OP_TOKEN, 0, 9, 0, 0, 0, 0, 0), 1, '{ST_MISMATCH, 7'd1, 8'd1}});

    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(0, 15, 16, 64);
        1: configure(15, 0, 1, 1);
        2: configure($urandom_range(15), $urandom_range(15), $urandom_range(16, 1), 255);
        4: configure(3, 15, 16, 64);
        default: configure($urandom_range(15), $urandom_range(15), $urandom_range(16, 1),
                           $urandom_range(255, 1));
      endcase
      repeat (175) begin
        idle_gap(gaps[ph]);
        r = $urandom_range(99);
        if (!shadow_parsing && r < 50) it = rand_fields(OP_START);
        else if (r < 8) it = rand_fields(OP_TABLE);
        else if (r < 14) it = rand_fields(OP_PROD);
        else if (r < 18) it = rand_fields(OP_START);
        else begin
          it = rand_fields(OP_TOKEN);
          if ($urandom_range(99) < 85) it.term = guided_token();
        end
        send(it, 1'b0, none);
      end
    end
    start <= 1'b0;

    // Drain, then give the engine a little slack
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d transactions under 7 register settings", items_sent);
    $display("accepts %0d, tokens consumed %0d, errors %0d", status_seen[ST_ACCEPT],
             status_seen[ST_CONSUMED], status_seen[ST_MISMATCH] + status_seen[ST_LEXICAL] +
             status_seen[ST_NOENTRY] + status_seen[ST_OVERFLOW] + status_seen[ST_LIMIT]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches counted", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
